/* rtl/binary_to_decimal_ascii_macros.svh */
// Assertion macros for the binary to decimal ASCII converter.
// Used by rtl/binary_to_decimal_ascii.sv; no other dependencies.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b2da assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b2da assertion failed");

`else

`define B2DA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/b2da_pkg.sv */
// Shared constants and helpers for the binary to decimal ASCII converter.
// Used by rtl/b2da_dabble_stage.sv and rtl/binary_to_decimal_ascii.sv.
`default_nettype none

package b2da_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int DEFAULT_MAX_DIGITS  = 10;

    // Width of the value port, fixed by the interface.
    localparam int VALUE_PORT_W   = 32;
    localparam int FIXED_WIDTH_W  = 4;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 6;

    // Binary bits consumed by one conversion stage.
    localparam int BITS_PER_STAGE = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Decimal digits needed for any value of the given bit width.
    // 2^w - 1 has as many digits as 2^w, which is floor(w*log10(2)) + 1.
    function automatic int bcd_digits(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

endpackage

`default_nettype wire

/* rtl/binary_to_decimal_ascii.sv */
// An accepted item passes through the dabble stage registers and the emitter register before
// the output register strobes its first digit. The digit emitter drives the single output strobe,
// one digit per cycle, 1 to MAX_DIGITS digits (up to 10) per item; conversion itself is pipelined.
// The receiver cannot stall; busy reflects the emitter backing up and is high during reset.
// Reset (synchronous, active low) clears all valid bits; in-flight items are dropped.
// Depends on rtl/b2da_pkg.sv, rtl/b2da_dabble_stage.sv, rtl/binary_to_decimal_ascii_macros.svh.
`default_nettype none

`include "binary_to_decimal_ascii_macros.svh"

module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = b2da_pkg::DEFAULT_VALUE_WIDTH,
    parameter int MAX_DIGITS  = b2da_pkg::DEFAULT_MAX_DIGITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic [b2da_pkg::VALUE_PORT_W-1:0]     i_value,
    input  wire logic [b2da_pkg::FIXED_WIDTH_W-1:0]    i_fixed_width,
    output logic                                       o_valid,
    output logic      [b2da_pkg::CHAR_W-1:0]           o_digit_char,
    output logic                                       o_last
);

    // The conversion is a double-dabble pipeline: each stage shifts in
    // BITS_PER_STAGE binary bits, correcting every BCD digit before each
    // shift. The last stage handles whatever bits remain.
    localparam int BPS        = b2da_pkg::BITS_PER_STAGE;
    localparam int NUM_STAGES = (VALUE_WIDTH + BPS - 1) / BPS;
    localparam int NUM_DIGITS = b2da_pkg::bcd_digits(VALUE_WIDTH);
    localparam int DW         = b2da_pkg::DIGIT_W;
    localparam int BCD_W      = NUM_DIGITS * DW;
    localparam int WW         = b2da_pkg::FIXED_WIDTH_W;

    // Digit positions in the emitter count down from count-1 to zero.
    localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Common width for digit counts, wide enough for the request field,
    // the converter's digit count and MAX_DIGITS.
    localparam int CW_A  = $clog2(NUM_DIGITS + 1);
    localparam int CW_B  = $clog2(MAX_DIGITS + 1);
    localparam int CW_AB = (CW_A > CW_B) ? CW_A : CW_B;
    localparam int CMP_W = (CW_AB > WW) ? CW_AB : WW;

    // Stage s takes index s of these buses and drives index s+1.
    logic                   stage_valid [NUM_STAGES+1];
    logic                   stage_ready [NUM_STAGES+1];
    logic [VALUE_WIDTH-1:0] stage_bin   [NUM_STAGES+1];
    logic [BCD_W-1:0]       stage_bcd   [NUM_STAGES+1];
    logic [WW-1:0]          stage_width [NUM_STAGES+1];

    // Only the low VALUE_WIDTH bits of the value take part.
    generate
        if (VALUE_WIDTH <= b2da_pkg::VALUE_PORT_W) begin : g_in_trunc
            assign stage_bin[0] = i_value[VALUE_WIDTH-1:0];
        end else begin : g_in_ext
            assign stage_bin[0] = {{(VALUE_WIDTH - b2da_pkg::VALUE_PORT_W){1'b0}}, i_value};
        end
    endgenerate

    assign stage_valid[0] = i_start;
    assign stage_bcd[0]   = '0;
    assign stage_width[0] = i_fixed_width;

    generate
        for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
            localparam int REMAIN = VALUE_WIDTH - s * BPS;
            localparam int STEPS  = (REMAIN < BPS) ? REMAIN : BPS;

            b2da_dabble_stage #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .NUM_DIGITS  (NUM_DIGITS),
                .STEPS       (STEPS)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (stage_valid[s]),
                .i_bin   (stage_bin[s]),
                .i_bcd   (stage_bcd[s]),
                .i_width (stage_width[s]),
                .i_ready (stage_ready[s+1]),
                .o_ready (stage_ready[s]),
                .o_valid (stage_valid[s+1]),
                .o_bin   (stage_bin[s+1]),
                .o_bcd   (stage_bcd[s+1]),
                .o_width (stage_width[s+1])
            );
        end
    endgenerate

    // An item is taken whenever the first stage can load. While reset is held
    // nothing is taken, so busy stays high then.
    assign o_busy = !stage_ready[0] || !i_rst_n;

    // The final binary remainder is all shifted out; it is not needed.
    logic unused_bin;
    assign unused_bin = ^stage_bin[NUM_STAGES];

    // Digit emitter: holds the low MAX_DIGITS decimal digits of one item
    // and walks its position down from the most significant digit wanted.
    logic                r_em_valid;
    logic [POS_W-1:0]    r_em_pos;
    logic [DW-1:0]       r_em_digits [MAX_DIGITS];
    logic                em_ready;

    logic [DW-1:0]       n_digits [MAX_DIGITS];
    logic [POS_W-1:0]    n_pos;

    assign em_ready = !r_em_valid || (r_em_pos == '0);
    assign stage_ready[NUM_STAGES] = em_ready;

    // Digits above the converter's range are zero.
    generate
        for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_digit
            if (k < NUM_DIGITS) begin : g_conv
                assign n_digits[k] = stage_bcd[NUM_STAGES][k*DW +: DW];
            end else begin : g_zero
                assign n_digits[k] = '0;
            end
        end
    endgenerate

    // Digit count: in minimal mode, one past the highest nonzero digit
    // (a lone zero for the value zero); otherwise the requested width.
    // Either is capped at MAX_DIGITS.
    always_comb begin
        logic [CMP_W-1:0] cnt_min;
        logic [CMP_W-1:0] cnt;
        cnt_min = CMP_W'(1);
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (stage_bcd[NUM_STAGES][k*DW +: DW] != '0) begin
                cnt_min = CMP_W'(k + 1);
            end
        end
        if (stage_width[NUM_STAGES] == '0) begin
            cnt = cnt_min;
        end else begin
            cnt = CMP_W'(stage_width[NUM_STAGES]);
        end
        if (cnt > CMP_W'(MAX_DIGITS)) begin
            cnt = CMP_W'(MAX_DIGITS);
        end
        n_pos = POS_W'(cnt - CMP_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid <= 1'b0;
        end else if (em_ready) begin
            r_em_valid <= stage_valid[NUM_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_ready) begin
            if (stage_valid[NUM_STAGES]) begin
                r_em_digits <= n_digits;
                r_em_pos    <= n_pos;
            end
        end else begin
            r_em_pos <= r_em_pos - POS_W'(1);
        end
    end

    // Output register: one digit per cycle while the emitter holds an item.
    logic                          r_out_valid;
    logic [b2da_pkg::CHAR_W-1:0]   r_out_char;
    logic                          r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_em_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= b2da_pkg::ASCII_ZERO + {2'b00, r_em_digits[r_em_pos]};
        r_out_last <= (r_em_pos == '0);
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last       = r_out_last;

    // A digit is always an ASCII decimal character.
    `B2DA_ASSERT_IMPL(a_char_range, i_clk, i_rst_n, o_valid, (o_digit_char >= 6'd48) && (o_digit_char <= 6'd57))

    // A run has no gaps: a digit that is not the last is followed by another.
    `B2DA_ASSERT_NEXT(a_run_contiguous, i_clk, i_rst_n, o_valid && !o_last, o_valid)

    // The emitter position steps down by one while a run is in progress.
    `B2DA_ASSERT_NEXT(a_pos_step, i_clk, i_rst_n, r_em_valid && (r_em_pos != '0), r_em_valid && (r_em_pos == $past(r_em_pos) - POS_W'(1)))

endmodule

`default_nettype wire

/* rtl/b2da_dabble_stage.sv */
// One registered stage of the shift-and-add-3 binary to BCD converter.
// Depends on rtl/b2da_pkg.sv.
`default_nettype none

module b2da_dabble_stage #(
    parameter int VALUE_WIDTH = b2da_pkg::DEFAULT_VALUE_WIDTH,
    parameter int NUM_DIGITS  = b2da_pkg::bcd_digits(b2da_pkg::DEFAULT_VALUE_WIDTH),
    parameter int STEPS       = b2da_pkg::BITS_PER_STAGE
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_valid,
    input  wire logic [VALUE_WIDTH-1:0]                      i_bin,
    input  wire logic [NUM_DIGITS*b2da_pkg::DIGIT_W-1:0]     i_bcd,
    input  wire logic [b2da_pkg::FIXED_WIDTH_W-1:0]          i_width,
    input  wire logic                                        i_ready,
    output logic                                             o_ready,
    output logic                                             o_valid,
    output logic      [VALUE_WIDTH-1:0]                      o_bin,
    output logic      [NUM_DIGITS*b2da_pkg::DIGIT_W-1:0]     o_bcd,
    output logic      [b2da_pkg::FIXED_WIDTH_W-1:0]          o_width
);

    localparam int BCD_W = NUM_DIGITS * b2da_pkg::DIGIT_W;

    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [b2da_pkg::FIXED_WIDTH_W-1:0] r_width;

    logic [VALUE_WIDTH-1:0] n_bin;
    logic [BCD_W-1:0]       n_bcd;

    // Each step corrects every digit of five or more, then shifts one bit in.
    always_comb begin
        logic [BCD_W+VALUE_WIDTH-1:0] acc;
        acc = {i_bcd, i_bin};
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (acc[VALUE_WIDTH + d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= 4'd5) begin
                    acc[VALUE_WIDTH + d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                        acc[VALUE_WIDTH + d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + 4'd3;
                end
            end
            acc = acc << 1;
        end
        n_bin = acc[VALUE_WIDTH-1:0];
        n_bcd = acc[BCD_W+VALUE_WIDTH-1:VALUE_WIDTH];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bin   <= n_bin;
            r_bcd   <= n_bcd;
            r_width <= i_width;
        end
    end

    assign o_valid = r_valid;
    assign o_bin   = r_bin;
    assign o_bcd   = r_bcd;
    assign o_width = r_width;

endmodule

`default_nettype wire

/* bench/tb_binary_to_decimal_ascii.sv */
// Self-checking testbench for binary_to_decimal_ascii: drives value and width items through
// the start/busy handshake and checks every ASCII digit strobe against an in-bench predictor.
// Depends on rtl/b2da_pkg.sv and the binary_to_decimal_ascii RTL.

module tb_binary_to_decimal_ascii;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is instantiated with its default parameters, so the predictor uses the same.
    localparam int VALUE_BITS      = b2da_pkg::DEFAULT_VALUE_WIDTH;
    localparam int DIGIT_LIMIT     = b2da_pkg::DEFAULT_MAX_DIGITS;
    localparam int IDLE_LIMIT      = 2000;  // cycles with no activity before giving up
    localparam int DRAIN_CYCLES    = 20;    // settle time after the last digit
    localparam int RESET_CYCLES    = 9;

    // One expected digit strobe.
    typedef struct packed {
        logic [b2da_pkg::CHAR_W-1:0] digit_char;
        logic                        last;
    } t_digit_strobe;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_start = 1'b0;
    logic [b2da_pkg::VALUE_PORT_W-1:0]   i_value = '0;
    logic [b2da_pkg::FIXED_WIDTH_W-1:0]  i_fixed_width = '0;
    logic                                o_busy;
    logic                                o_valid;
    logic [b2da_pkg::CHAR_W-1:0]         o_digit_char;
    logic                                o_last;

    t_digit_strobe pending_digits[$];
    int            mismatch_count = 0;
    int            quiet_cycles = 0;

    binary_to_decimal_ascii uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_value       (i_value),
        .i_fixed_width (i_fixed_width),
        .o_valid       (o_valid),
        .o_digit_char  (o_digit_char),
        .o_last        (o_last)
    );

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 0;
    end

    // Every mismatch goes through here: one line and one count.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Works out the digit strobes that one accepted item must produce and queues them.
    // The value is split into decimal digits, low order first; in minimal mode the count
    // runs up to the highest nonzero digit (at least one), otherwise it is the requested
    // width. Either way it saturates at the digit limit of the block.
    function automatic void predict_digits(input logic [b2da_pkg::VALUE_PORT_W-1:0] value,
                                           input logic [b2da_pkg::FIXED_WIDTH_W-1:0] width);
        logic [63:0]   remainder;
        logic [3:0]    digits[20];
        int            count;
        int            pos;
        t_digit_strobe strobe;
        remainder = 64'(value) & ((64'd1 << VALUE_BITS) - 64'd1);
        for (int k = 0; k < 20; k++) begin
            digits[k] = 4'(remainder % 64'd10);
            remainder = remainder / 64'd10;
        end
        if (width == '0) begin
            count = 1;
            for (int k = 0; k < 20; k++) begin
                if (digits[k] != 4'd0) begin
                    count = k + 1;
                end
            end
        end else begin
            count = int'(width);
        end
        if (count > DIGIT_LIMIT) begin
            count = DIGIT_LIMIT;
        end
        for (int k = 0; k < count; k++) begin
            pos = count - 1 - k;
            strobe.digit_char = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digits[pos]);
            strobe.last = (pos == 0);
            pending_digits.push_back(strobe);
        end
    endfunction

    // Presents one item and holds it until the block takes it. Start is left high on
    // return, so a following item goes out back to back unless an idle burst lowers it.
    task automatic send_item(input logic [b2da_pkg::VALUE_PORT_W-1:0] value,
                             input logic [b2da_pkg::FIXED_WIDTH_W-1:0] width);
        i_start <= 1'b1;
        i_value <= value;
        i_fixed_width <= width;
        do begin
            @(posedge i_clk);
        end while (o_busy !== 1'b0);
        predict_digits(value, width);
    endtask

    // Drops start while the data ports carry noise the block must ignore; n sets how long.
    task automatic idle_inputs(input int n);
        repeat (n) begin
            i_start <= 1'b0;
            i_value <= $urandom;
            i_fixed_width <= b2da_pkg::FIXED_WIDTH_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // Roughly one item in three is followed by an idle burst.
    task automatic maybe_idle();
        if ($urandom_range(0, 2) == 0) begin
            idle_inputs($urandom_range(1, 10));
        end
    endtask

    // Values with a random bit length, so that every digit count shows up often.
    function automatic logic [b2da_pkg::VALUE_PORT_W-1:0] random_value();
        return $urandom >> $urandom_range(0, b2da_pkg::VALUE_PORT_W - 1);
    endfunction

    // Extremes of both fields, most width requests including the saturated ones,
    // zero in minimal mode, and digit-count boundaries.
    task automatic test_directed();
        logic [b2da_pkg::VALUE_PORT_W-1:0]  values[24];
        logic [b2da_pkg::FIXED_WIDTH_W-1:0] widths[24];
        values = '{32'd0, 32'd0, 32'd0, 32'd7, 32'd9, 32'd10, 32'd99, 32'd100,
                   32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'd12345, 32'd12345, 32'd42, 32'd123456789, 32'd5,
                   32'd1000, 32'd999999999, 32'hAAAA_AAAA, 32'h5555_5555, 32'd987654321,
                   32'd100};
        widths = '{4'd0, 4'd1, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
                   4'd0, 4'd0, 4'd10, 4'd15,
                   4'd1, 4'd3, 4'd4, 4'd4, 4'd11, 4'd12,
                   4'd13, 4'd14, 4'd0, 4'd9, 4'd2,
                   4'd5};
        for (int k = 0; k < 24; k++) begin
            send_item(values[k], widths[k]);
            maybe_idle();
        end
    endtask

    // Minimal mode on values of every magnitude.
    task automatic test_random_minimal(input int n);
        repeat (n) begin
            send_item(random_value(), '0);
            maybe_idle();
        end
    endtask

    // Fixed width over the whole 4-bit request range, with the common 3 and 4 favored.
    task automatic test_random_fixed(input int n);
        logic [b2da_pkg::FIXED_WIDTH_W-1:0] width;
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                width = b2da_pkg::FIXED_WIDTH_W'($urandom_range(3, 4));
            end else begin
                width = b2da_pkg::FIXED_WIDTH_W'($urandom_range(1, 15));
            end
            send_item(($urandom_range(0, 1) == 1) ? $urandom : random_value(), width);
            maybe_idle();
        end
    endtask

    // Back-to-back items with no idling, mixing both modes, to keep the emitter saturated.
    task automatic test_back_to_back(input int n);
        repeat (n) begin
            send_item(random_value(), b2da_pkg::FIXED_WIDTH_W'($urandom_range(0, 15)));
        end
    endtask

    // Digit checker: the receiver cannot stall, so every strobe is taken at the edge that
    // ends its cycle and compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_digit_strobe want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_digits.size() == 0) begin
                report_mismatch($sformatf("unexpected digit 0x%0h last %b",
                                          o_digit_char, o_last));
            end else begin
                want = pending_digits.pop_front();
                if (o_digit_char !== want.digit_char) begin
                    report_mismatch($sformatf("digit_char 0x%0h, expected 0x%0h",
                                              o_digit_char, want.digit_char));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last %b, expected %b", o_last, want.last));
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither an item nor a digit moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && o_busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_minimal(35);
        test_random_fixed(35);
        // The last stretch runs without any idling.
        test_back_to_back(36);
        i_start <= 1'b0;

        // Let the outstanding digits drain, then allow some extra cycles for stray strobes.
        while (pending_digits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_digits.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* binary_to_decimal_ascii.f */
+incdir+rtl
rtl/b2da_pkg.sv
rtl/b2da_dabble_stage.sv
rtl/binary_to_decimal_ascii.sv
bench/tb_binary_to_decimal_ascii.sv
